// ===== rtl/core/swd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_pkg
// Shared types, role and status codes and the operand template ROM of the
// SPIR-V word stream decoder.
// ---------------------------------------------------------------------------
package swd_pkg;

  localparam logic [31:0] SPIRV_MAGIC = 32'h0723_0203;
  localparam logic [2:0]  HDR_WORDS   = 3'd5;
  localparam logic [2:0]  HDR_LAST_FIELD = 3'd4;
  localparam int          TMPL_W      = 5;
  localparam int          TMPL_PARTS  = 9;

  // word roles
  localparam logic [4:0] ROLE_MAGIC      = 5'd0;
  localparam logic [4:0] ROLE_SCHEMA     = 5'd4;
  localparam logic [4:0] ROLE_INSTR      = 5'd5;
  localparam logic [4:0] ROLE_ID         = 5'd7;
  localparam logic [4:0] ROLE_ID_LIST    = 5'd9;
  localparam logic [4:0] ROLE_NUM        = 5'd10;
  localparam logic [4:0] ROLE_STRING     = 5'd11;
  localparam logic [4:0] ROLE_WORD_LIST  = 5'd12;
  localparam logic [4:0] ROLE_UNTAGGED   = 5'd20;

  // latched status
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_SPIRV   = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
  localparam logic [2:0] ST_NO_TERM     = 3'd3;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;

  // template part byte: [4:0] role, [6:5] slot, [7] optional
  localparam logic [7:0] P_NONE = 8'h00;
  localparam logic [7:0] P_RES  = 8'h06;
  localparam logic [7:0] P_ID0  = 8'h07;
  localparam logic [7:0] P_ID1  = 8'h27;
  localparam logic [7:0] P_OID  = 8'h88;
  localparam logic [7:0] P_IDL  = 8'h89;
  localparam logic [7:0] P_NM0  = 8'h0A;
  localparam logic [7:0] P_NM1  = 8'h2A;
  localparam logic [7:0] P_NM2  = 8'h4A;
  localparam logic [7:0] P_NM3  = 8'h6A;
  localparam logic [7:0] P_STR  = 8'h0B;
  localparam logic [7:0] P_WDL  = 8'h8C;
  localparam logic [7:0] P_EXM  = 8'h0D;
  localparam logic [7:0] P_SCL  = 8'h0E;
  localparam logic [7:0] P_DIM  = 8'h0F;
  localparam logic [7:0] P_ACQ  = 8'h10;
  localparam logic [7:0] P_OAQ  = 8'h90;
  localparam logic [7:0] P_DEC  = 8'h11;
  localparam logic [7:0] P_FMT  = 8'h12;
  localparam logic [7:0] P_FCT  = 8'h13;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_INSTR,
    KIND_OPERAND
  } kind_t;

  // opt_from: first step from which all remaining parts are optional
  typedef struct packed {
    logic [3:0]                  n;
    logic [3:0]                  opt_from;
    logic [TMPL_PARTS-1:0][7:0]  parts;
  } tmpl_t;

  typedef struct packed {
    logic              hit;
    logic [TMPL_W-1:0] id;
  } tmpl_lookup_t;

  // one classified word on its way from front to back
  typedef struct packed {
    kind_t             kind;
    logic [2:0]        hdr_field;
    logic [15:0]       opcode;
    logic [TMPL_W-1:0] tmpl_id;
    logic              known;
    logic              iend;
    logic [2:0]        ferr;
    logic [31:0]       value;
    logic              last;
  } swd_rec_t;

  function automatic tmpl_t mk(input logic [3:0] n, input logic [3:0] of,
                               input logic [7:0] p0 = P_NONE, input logic [7:0] p1 = P_NONE,
                               input logic [7:0] p2 = P_NONE, input logic [7:0] p3 = P_NONE,
                               input logic [7:0] p4 = P_NONE, input logic [7:0] p5 = P_NONE,
                               input logic [7:0] p6 = P_NONE, input logic [7:0] p7 = P_NONE,
                               input logic [7:0] p8 = P_NONE);
    tmpl_t t;
    t.n        = n;
    t.opt_from = of;
    t.parts[0] = p0;
    t.parts[1] = p1;
    t.parts[2] = p2;
    t.parts[3] = p3;
    t.parts[4] = p4;
    t.parts[5] = p5;
    t.parts[6] = p6;
    t.parts[7] = p7;
    t.parts[8] = p8;
    return t;
  endfunction

  function automatic tmpl_lookup_t tmpl_lookup(input logic [15:0] op);
    tmpl_lookup_t lk;
    lk.hit = 1'b1;
    lk.id  = '0;
    case (op)
      16'd0:                      lk.id = 5'd0;
      16'd1, 16'd41, 16'd42:      lk.id = 5'd1;
      16'd2, 16'd4:               lk.id = 5'd2;
      16'd5:                      lk.id = 5'd3;
      16'd6:                      lk.id = 5'd4;
      16'd7, 16'd31:              lk.id = 5'd5;
      16'd8:                      lk.id = 5'd6;
      16'd15:                     lk.id = 5'd7;
      16'd19, 16'd20, 16'd26,
      16'd34, 16'd35, 16'd36,
      16'd37:                     lk.id = 5'd8;
      16'd21:                     lk.id = 5'd9;
      16'd22:                     lk.id = 5'd10;
      16'd23, 16'd24:             lk.id = 5'd11;
      16'd25:                     lk.id = 5'd12;
      16'd27, 16'd29:             lk.id = 5'd13;
      16'd28:                     lk.id = 5'd14;
      16'd30:                     lk.id = 5'd15;
      16'd32:                     lk.id = 5'd16;
      16'd33:                     lk.id = 5'd17;
      16'd38:                     lk.id = 5'd18;
      16'd39:                     lk.id = 5'd19;
      16'd43:                     lk.id = 5'd20;
      16'd44:                     lk.id = 5'd21;
      16'd54:                     lk.id = 5'd22;
      16'd59:                     lk.id = 5'd23;
      16'd71:                     lk.id = 5'd24;
      16'd72:                     lk.id = 5'd25;
      default:                    lk.hit = 1'b0;
    endcase
    return lk;
  endfunction

  function automatic tmpl_t tmpl_entry(input logic [TMPL_W-1:0] id);
    tmpl_t t;
    case (id)
      5'd0:    t = mk(4'd0, 4'd0);
      5'd1:    t = mk(4'd2, 4'd2, P_ID0, P_RES);
      5'd2:    t = mk(4'd1, 4'd1, P_STR);
      5'd3:    t = mk(4'd2, 4'd2, P_ID0, P_STR);
      5'd4:    t = mk(4'd3, 4'd3, P_ID0, P_NM0, P_STR);
      5'd5:    t = mk(4'd2, 4'd2, P_RES, P_STR);
      5'd6:    t = mk(4'd3, 4'd3, P_ID0, P_NM0, P_NM1);
      5'd7:    t = mk(4'd4, 4'd3, P_EXM, P_ID0, P_STR, P_IDL);
      5'd8:    t = mk(4'd1, 4'd1, P_RES);
      5'd9:    t = mk(4'd3, 4'd3, P_RES, P_NM0, P_NM1);
      5'd10:   t = mk(4'd2, 4'd2, P_RES, P_NM0);
      5'd11:   t = mk(4'd3, 4'd3, P_RES, P_ID0, P_NM0);
      5'd12:   t = mk(4'd9, 4'd8, P_RES, P_ID0, P_DIM, P_NM0, P_NM1, P_NM2, P_NM3,
                      P_FMT, P_OAQ);
      5'd13:   t = mk(4'd2, 4'd2, P_RES, P_ID0);
      5'd14:   t = mk(4'd3, 4'd3, P_RES, P_ID0, P_ID1);
      5'd15:   t = mk(4'd2, 4'd1, P_RES, P_IDL);
      5'd16:   t = mk(4'd3, 4'd3, P_RES, P_SCL, P_ID0);
      5'd17:   t = mk(4'd3, 4'd2, P_RES, P_ID0, P_IDL);
      5'd18:   t = mk(4'd2, 4'd2, P_RES, P_ACQ);
      5'd19:   t = mk(4'd2, 4'd2, P_ID0, P_SCL);
      5'd20:   t = mk(4'd3, 4'd2, P_ID0, P_RES, P_WDL);
      5'd21:   t = mk(4'd3, 4'd2, P_ID0, P_RES, P_IDL);
      5'd22:   t = mk(4'd4, 4'd4, P_ID0, P_RES, P_FCT, P_ID1);
      5'd23:   t = mk(4'd4, 4'd3, P_ID0, P_RES, P_SCL, P_OID);
      5'd24:   t = mk(4'd3, 4'd2, P_ID0, P_DEC, P_WDL);
      5'd25:   t = mk(4'd4, 4'd3, P_ID0, P_NM0, P_DEC, P_WDL);
      default: t = mk(4'd0, 4'd0);
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/swd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_if
// Valid/ready channels of the decoder: input words and labelled results.
// ---------------------------------------------------------------------------
interface swd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

interface swd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  role;
  logic [1:0]  slot_index;
  logic [15:0] opcode;
  logic [31:0] value;
  logic        known_opcode;
  logic        instr_end;
  logic [2:0]  status;

  modport source (output valid, output role, output slot_index, output opcode, output value,
                  output known_opcode, output instr_end, output status, input ready);
  modport sink   (input valid, input role, input slot_index, input opcode, input value,
                  input known_opcode, input instr_end, input status, output ready);
endinterface

// ===== rtl/core/swd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_front
// Frames the word stream: header position, instruction length countdown and
// template lookup on each instruction header; raises framing errors.
// ---------------------------------------------------------------------------
module swd_front import swd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  swd_in_if.sink   words,
  output logic     push,
  output swd_rec_t rec,
  input  logic     full
);

  logic [2:0]        hdr_pos, hdr_pos_next;
  logic [15:0]       words_left, words_left_next;
  logic [TMPL_W-1:0] tmpl_id, tmpl_id_next;
  logic              known, known_next;
  logic [15:0]       len;
  tmpl_lookup_t      look;
  tmpl_t             look_ent;

  assign words.ready = !full;
  assign push        = words.valid && !full;

  always_comb begin
    look     = tmpl_lookup(words.word[15:0]);
    look_ent = tmpl_entry(look.id);
    len      = words.word[31:16];

    rec           = '0;
    rec.value     = words.word;
    rec.last      = words.last_word;
    rec.tmpl_id   = tmpl_id;
    rec.known     = known;
    rec.ferr      = ST_OK;

    hdr_pos_next    = hdr_pos;
    words_left_next = words_left;
    tmpl_id_next    = tmpl_id;
    known_next      = known;

    if (hdr_pos < HDR_WORDS) begin
      rec.kind      = KIND_HEADER;
      rec.hdr_field = hdr_pos;
      if ((hdr_pos == 3'd0 && words.word != SPIRV_MAGIC) ||
          (words.last_word && hdr_pos < HDR_LAST_FIELD)) begin
        rec.ferr = ST_NOT_SPIRV;
      end
      hdr_pos_next = hdr_pos + 3'd1;
    end else if (words_left == '0) begin
      rec.kind     = KIND_INSTR;
      rec.opcode   = words.word[15:0];
      rec.known    = look.hit;
      rec.tmpl_id  = look.id;
      tmpl_id_next = look.id;
      known_next   = look.hit;
      if (len == '0) begin
        // zero word count would never end: flag and close the instruction
        rec.iend        = 1'b1;
        rec.ferr        = ST_LEN_MISMATCH;
        words_left_next = '0;
      end else begin
        words_left_next = len - 16'd1;
        rec.iend        = (words_left_next == '0);
        if (words.last_word && words_left_next != '0) begin
          rec.ferr = ST_INCOMPLETE;
        end else if (rec.iend && look.hit && look_ent.opt_from != 4'd0) begin
          rec.ferr = ST_LEN_MISMATCH;
        end
      end
    end else begin
      rec.kind        = KIND_OPERAND;
      words_left_next = words_left - 16'd1;
      rec.iend        = (words_left_next == '0);
      if (words.last_word && !rec.iend) begin
        rec.ferr = ST_INCOMPLETE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos    <= '0;
      words_left <= '0;
      tmpl_id    <= '0;
      known      <= 1'b0;
    end else if (push) begin
      if (words.last_word) begin
        hdr_pos    <= '0;
        words_left <= '0;
        tmpl_id    <= '0;
        known      <= 1'b0;
      end else begin
        hdr_pos    <= hdr_pos_next;
        words_left <= words_left_next;
        tmpl_id    <= tmpl_id_next;
        known      <= known_next;
      end
    end
  end

endmodule

// ===== rtl/core/swd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_queue
// Short FIFO of classified words between the front and the back.
// ---------------------------------------------------------------------------
module swd_queue import swd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  swd_rec_t wr_rec,
  output logic     full,
  input  logic     pop,
  output swd_rec_t rd_rec,
  output logic     empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  swd_rec_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/swd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_back
// Walks the operand template, tags each word, latches the first error and
// holds the labelled word in the output register.
// ---------------------------------------------------------------------------
module swd_back import swd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  swd_rec_t  head,
  input  logic      empty,
  output logic      pop,
  swd_out_if.source labels
);

  logic [2:0]  err, err_next;
  logic [3:0]  step, step_next;
  logic        in_str, in_str_next;
  logic [15:0] op_hold, op_hold_next;

  logic        out_valid;
  logic [4:0]  role_r, role_next;
  logic [1:0]  slot_r, slot_next;
  logic [15:0] op_r, op_next;
  logic [31:0] value_r;
  logic        known_r, known_next;
  logic        iend_r, iend_next;
  logic [2:0]  status_r;

  tmpl_t       ent;
  logic        step_ok;
  logic [7:0]  part;
  logic        zero_byte;
  logic [2:0]  tpl_err;

  assign pop = !empty && (!out_valid || labels.ready);

  always_comb begin
    ent       = tmpl_entry(head.tmpl_id);
    step_ok   = step < ent.n;
    part      = step_ok ? ent.parts[step] : P_NONE;
    zero_byte = (head.value[7:0] == 8'h00) || (head.value[15:8] == 8'h00) ||
                (head.value[23:16] == 8'h00) || (head.value[31:24] == 8'h00);

    role_next    = ROLE_UNTAGGED;
    slot_next    = '0;
    op_next      = op_hold;
    known_next   = 1'b0;
    iend_next    = 1'b0;
    err_next     = err;
    step_next    = step;
    in_str_next  = in_str;
    op_hold_next = op_hold;
    tpl_err      = ST_OK;

    // once an error is latched every word passes through untagged
    if (err == ST_OK) begin
      case (head.kind)
        KIND_HEADER: begin
          role_next = {2'b00, head.hdr_field};
          op_next   = '0;
          err_next  = head.ferr;
        end
        KIND_INSTR: begin
          role_next    = ROLE_INSTR;
          op_next      = head.opcode;
          op_hold_next = head.opcode;
          known_next   = head.known;
          iend_next    = head.iend;
          step_next    = '0;
          in_str_next  = 1'b0;
          err_next     = head.ferr;
        end
        KIND_OPERAND: begin
          known_next = head.known;
          iend_next  = head.iend;
          if (head.known) begin
            if (in_str) begin
              role_next = ROLE_STRING;
              if (zero_byte) begin
                in_str_next = 1'b0;
                step_next   = step + 4'd1;
              end
            end else if (step_ok) begin
              role_next = part[4:0];
              if (role_next inside {ROLE_ID, ROLE_NUM}) begin
                slot_next = part[6:5];
              end
              if (role_next inside {ROLE_ID_LIST, ROLE_WORD_LIST}) begin
                // list element: template stays on this part
              end else if (role_next == ROLE_STRING) begin
                if (zero_byte) begin
                  step_next = step + 4'd1;
                end else begin
                  in_str_next = 1'b1;
                end
              end else begin
                step_next = step + 4'd1;
              end
            end else begin
              tpl_err = ST_LEN_MISMATCH;
            end
            if (head.iend && tpl_err == ST_OK) begin
              if (in_str_next) begin
                tpl_err = ST_NO_TERM;
              end else if (step_next < ent.opt_from) begin
                tpl_err = ST_LEN_MISMATCH;
              end
            end
          end
          err_next = (tpl_err != ST_OK) ? tpl_err : head.ferr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      err       <= ST_OK;
      step      <= '0;
      in_str    <= 1'b0;
      op_hold   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.last) begin
          err     <= ST_OK;
          step    <= '0;
          in_str  <= 1'b0;
          op_hold <= '0;
        end else begin
          err     <= err_next;
          step    <= step_next;
          in_str  <= in_str_next;
          op_hold <= op_hold_next;
        end
      end else if (labels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      role_r   <= role_next;
      slot_r   <= slot_next;
      op_r     <= op_next;
      value_r  <= head.value;
      known_r  <= known_next;
      iend_r   <= iend_next;
      status_r <= err_next;
    end
  end

  assign labels.valid        = out_valid;
  assign labels.role         = role_r;
  assign labels.slot_index   = slot_r;
  assign labels.opcode       = op_r;
  assign labels.value        = value_r;
  assign labels.known_opcode = known_r;
  assign labels.instr_end    = iend_r;
  assign labels.status       = status_r;

endmodule

// ===== rtl/core/spirv_word_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spirv_word_stream_decoder_top
// Labels each word of a SPIR-V module with its role in the binary.
// ---------------------------------------------------------------------------
// Usage:
//   words  : valid/ready input, one 32-bit word per request; last_word marks
//            the final word of a module.
//   labels : valid/ready output, one labelled word per input word, in order:
//            role, slot_index, opcode, value, known_opcode, instr_end and the
//            latched status after that word.
//   Throughput is one word per cycle while labels is ready. A word passes
//   from input request to output valid through the front-to-back queue
//   and then the output register.
//   The front frames header and instruction lengths; the back walks the
//   operand template and latches the first error until the end of module.
//   When labels stalls, the queue (QUEUE_DEPTH entries, at least 2) fills
//   and then words.ready drops; nothing is dropped or repeated.
//   Reset clears both halves and the queue; the first word after reset or
//   after a last_word is treated as the magic number of a new module.
// ---------------------------------------------------------------------------
module spirv_word_stream_decoder_top import swd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  swd_in_if.sink    words,
  swd_out_if.source labels
);

  logic     push, full, pop, empty;
  swd_rec_t wr_rec, rd_rec;

  swd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .words (words),
    .push  (push),
    .rec   (wr_rec),
    .full  (full)
  );

  swd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (full),
    .pop    (pop),
    .rd_rec (rd_rec),
    .empty  (empty)
  );

  swd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (rd_rec),
    .empty  (empty),
    .pop    (pop),
    .labels (labels)
  );

endmodule

// ===== rtl/core/swd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swd_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
module swd_checker import swd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  role,
  input logic [1:0]  slot_index,
  input logic [15:0] opcode,
  input logic [31:0] value,
  input logic        known_opcode,
  input logic        instr_end,
  input logic [2:0]  status
);

  logic [7:0] pending;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 8'd1;
    end else if (out_take && !in_take) begin
      pending <= pending - 8'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({role, slot_index, opcode, value, known_opcode, instr_end, status}))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result without a pending request");

  a_header_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && role <= ROLE_SCHEMA |->
      opcode == 16'd0 && !known_opcode && !instr_end && slot_index == 2'd0)
    else $error("header word carries instruction fields");

  a_slot_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_index != 2'd0 |-> role == ROLE_ID || role == ROLE_NUM)
    else $error("slot index on a non-indexed role");

endmodule

bind spirv_word_stream_decoder_top swd_checker u_swd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (words.valid),
  .in_ready     (words.ready),
  .out_valid    (labels.valid),
  .out_ready    (labels.ready),
  .role         (labels.role),
  .slot_index   (labels.slot_index),
  .opcode       (labels.opcode),
  .value        (labels.value),
  .known_opcode (labels.known_opcode),
  .instr_end    (labels.instr_end),
  .status       (labels.status)
);
